// ----- design/mic_pkg.sv -----
`default_nettype none
package mic_pkg;

    localparam int MIC_MAX_CPUS  = 6;
    localparam int MIC_MAX_LINES = 576;

    localparam logic [1:0] CMD_WR   = 2'd0;
    localparam logic [1:0] CMD_RD   = 2'd1;
    localparam logic [1:0] CMD_LVL  = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    localparam logic CFG_NUM_CPUS  = 1'b0;
    localparam logic [2:0] CFG_CPUS_RST  = 3'd6;
    localparam logic [4:0] CFG_WORDS_RST = 5'd18;

    localparam logic [15:0] A_REV      = 16'h0000;
    localparam logic [15:0] A_CAP      = 16'h0004;
    localparam logic [15:0] A_SRST     = 16'h000C;
    localparam logic [15:0] A_GCFG     = 16'h0010;
    localparam logic [15:0] A_WHO      = 16'h2000;
    localparam logic [15:0] A_ACK      = 16'h2004;
    localparam logic [15:0] A_ISET     = 16'h2008;
    localparam logic [15:0] A_ICLR     = 16'h200C;
    localparam logic [15:0] A_MSET     = 16'h2024;
    localparam logic [15:0] A_MCLR     = 16'h2028;
    localparam logic [15:0] A_DSET     = 16'h202C;
    localparam logic [15:0] A_DCLR     = 16'h2030;
    localparam logic [15:0] W_DEST     = 16'h3000;
    localparam logic [15:0] W_PSET     = 16'h4000;
    localparam logic [15:0] W_PCLR     = 16'h4080;
    localparam logic [15:0] W_MSET     = 16'h4100;
    localparam logic [15:0] W_MCLR     = 16'h4180;
    localparam logic [15:0] W_PRD      = 16'h4200;
    localparam logic [15:0] ALIAS_BASE = 16'h5000;
    localparam int          ALIAS_STRIDE = 'h80;

    localparam logic [31:0] REVISION  = 32'h0000_0002;
    localparam logic [31:0] ACK_SELF  = 32'h0004_0002;
    localparam logic [31:0] ACK_NORM  = 32'h0004_0001;
    localparam logic [31:0] ACK_LINE  = 32'h0001_0000;
    localparam logic [31:0] LINE_MASK = 32'h0000_03FF;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    typedef enum logic [4:0] {
        OP_ONE    = 5'b00001,
        OP_SOFT   = 5'b00010,
        OP_RDDEST = 5'b00100,
        OP_ACK    = 5'b01000,
        OP_TICK   = 5'b10000
    } t_op;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_SWEEP = 7'b0001000,
        S_DEST  = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
        logic scan;
        logic grab;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic ipi_hit;
        logic sweep_last;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- design/mic_ctrl.sv -----
`default_nettype none
module mic_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mic_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output mic_pkg::t_dp_cmd  o_cmd
);
    import mic_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                unique case (i_stat.op)
                    OP_ONE:    n_state = S_DONE;
                    OP_SOFT:   n_state = S_SWEEP;
                    OP_RDDEST: n_state = S_DEST;
                    OP_ACK:    n_state = i_stat.ipi_hit ? S_DONE : S_SCAN;
                    OP_TICK:   n_state = S_SCAN;
                    default:   n_state = S_DONE;
                endcase
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) n_state = S_DONE;
            end
            S_DEST: begin
                o_cmd.grab = 1'b1;
                n_state    = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/mic_dp.sv -----
`default_nettype none
module mic_dp #(
    parameter int MAX_CPUS  = mic_pkg::MIC_MAX_CPUS,
    parameter int MAX_LINES = mic_pkg::MIC_MAX_LINES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_index,
    input  logic [4:0]        i_cfg_data,
    input  logic [1:0]        i_cmd,
    input  logic [2:0]        i_cpu,
    input  logic [15:0]       i_addr,
    input  logic [31:0]       i_wdata,
    input  logic [9:0]        i_line,
    input  logic              i_level,
    input  logic              i_out_ready,
    input  mic_pkg::t_dp_cmd  i_ctl,
    output mic_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    output logic [31:0]       o_read_data,
    output logic [5:0]        o_raise_mask,
    output logic [5:0]        o_lower_mask
);
    import mic_pkg::*;

    localparam int NWORDS = MAX_LINES / 32;
    localparam int CW     = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int NCW    = $clog2(MAX_CPUS + 1);
    localparam int NWW    = $clog2(NWORDS + 1);
    localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int AW     = $clog2(MAX_LINES);
    localparam int LW     = $clog2(MAX_LINES + 1);
    localparam logic [15:0] ALIAS_LAST = 16'(32'(ALIAS_BASE) + MAX_CPUS * ALIAS_STRIDE - 4);

    // Configuration and effective counts.
    logic [2:0]          r_num_cpus;
    logic [4:0]          r_num_words;
    logic [NCW-1:0]      nc;
    logic [NWW-1:0]      nw;
    logic [LW-1:0]       nlines;
    logic [MAX_CPUS-1:0] cmask;

    // Request registers.
    logic [1:0]  r_cmd;
    logic [2:0]  r_cpu;
    logic [15:0] r_addr;
    logic [31:0] r_wdata;
    logic [9:0]  r_line;
    logic        r_level;

    // Interrupt state.
    logic [31:0]         r_pend [NWORDS];
    logic [31:0]         r_mask [NWORDS];
    logic [MAX_CPUS-1:0] r_ipend [MAX_CPUS];
    logic [MAX_CPUS-1:0] r_idefr [MAX_CPUS];
    logic [MAX_CPUS-1:0] r_iself;
    logic [MAX_CPUS-1:0] r_idself;
    logic [1:0]          r_imask [MAX_CPUS];
    logic [31:0]         r_gcfg;
    logic [31:0]         r_dest [MAX_LINES];
    logic [31:0]         r_dout;

    // Scan and sweep.
    logic [LW-1:0]       r_n;
    logic [LW-1:0]       r_nq;
    logic                r_qv;
    logic                r_live_q;
    logic [MAX_CPUS:0]   r_intr;
    logic [MAX_CPUS-1:0] r_cand;

    // Result and output.
    logic [31:0]         r_rd;
    logic [MAX_CPUS-1:0] r_raise;
    logic [MAX_CPUS-1:0] r_lower;
    logic                r_out_valid;
    logic [31:0]         r_out_rd;
    logic [5:0]          r_out_raise;
    logic [5:0]          r_out_lower;

    // Decode.
    logic            alias_in, alias_bad, valid_cpu, mapped, win_ok;
    logic [8:0]      alias_off;
    logic [3:0]      o_full;
    logic [CW-1:0]   oo;
    logic [15:0]     ra;
    logic [13:0]     a2;
    logic            in_dest, in_pset, in_pclr, in_mset, in_mclr, in_prd;
    logic [AW-1:0]   kd;
    logic [WW-1:0]   kw, lw, sw, qw, rsel;
    logic [4:0]      lb, sb, qb;
    logic            line_ok;
    logic [31:0]     w_pend, w_mask;
    logic [31:0]     rd_val, ack_val;
    logic            ack_self, ack_norm, is_ack, is_iset;
    logic [MAX_CPUS-1:0] raise_iset, lower_vec;
    logic [MAX_CPUS-1:0] m_pend [MAX_CPUS];
    logic [MAX_CPUS-1:0] m_self;
    logic [MAX_CPUS:0]   intr0;
    logic            hit_ack, ev_tick, found, scan_last, scan_done;
    logic [NCW-1:0]  first;
    logic [CW-1:0]   pick;
    logic [MAX_CPUS-1:0] dlo, avail;
    logic [MAX_CPUS:0]   dext, n_intr;
    logic [MAX_CPUS-1:0] n_cand;
    logic            mem_we;
    logic [AW-1:0]   waddr, raddr;
    logic [31:0]     mem_wdata;
    logic [MAX_CPUS+5:0] raise_pad, lower_pad;
    t_op             op;

    always_comb begin
        if (r_num_cpus == 3'd0) nc = NCW'(1);
        else if (32'(r_num_cpus) > 32'(MAX_CPUS)) nc = NCW'(MAX_CPUS);
        else nc = NCW'(r_num_cpus);
        if (r_num_words == 5'd0) nw = NWW'(1);
        else if (32'(r_num_words) > 32'(NWORDS)) nw = NWW'(NWORDS);
        else nw = NWW'(r_num_words);
        nlines = LW'(32'(nw) * 32);
        for (int i = 0; i < MAX_CPUS; i++) cmask[i] = (32'(i) < 32'(nc));
    end

    always_comb begin
        alias_in  = (r_addr >= ALIAS_BASE) && (r_addr <= ALIAS_LAST);
        alias_off = r_addr[15:7] - ALIAS_BASE[15:7];
        o_full    = alias_in ? alias_off[3:0] : {1'b0, r_cpu};
        valid_cpu = 32'(r_cpu) < 32'(nc);
        alias_bad = alias_in && (32'(alias_off[3:0]) >= 32'(nc));
        mapped    = valid_cpu && !alias_bad;
        oo        = CW'(o_full);
        ra        = alias_in ? {A_WHO[15:7], r_addr[6:0]} : r_addr;
        a2        = ra[15:2];
        win_ok    = 32'(ra[6:2]) < 32'(nw);
        in_pset   = (ra[15:7] == W_PSET[15:7]) && win_ok;
        in_pclr   = (ra[15:7] == W_PCLR[15:7]) && win_ok;
        in_mset   = (ra[15:7] == W_MSET[15:7]) && win_ok;
        in_mclr   = (ra[15:7] == W_MCLR[15:7]) && win_ok;
        in_prd    = (ra[15:7] == W_PRD[15:7]) && win_ok;
        in_dest   = (a2 >= W_DEST[15:2]) && (32'(a2 - W_DEST[15:2]) < 32'(nlines));
        kd        = AW'(a2 - W_DEST[15:2]);
        kw        = WW'(ra[6:2]);
        line_ok   = 32'(r_line) < 32'(nlines);
        lw        = WW'(r_line >> 5);
        lb        = r_line[4:0];
        sw        = WW'(r_n >> 5);
        sb        = r_n[4:0];
        qw        = WW'(r_nq >> 5);
        qb        = r_nq[4:0];
        rsel      = i_ctl.scan ? sw : ((r_cmd == CMD_LVL) ? lw : kw);
        w_pend    = r_pend[rsel];
        w_mask    = r_mask[rsel];
        is_ack    = (r_cmd == CMD_RD) && mapped && (ra == A_ACK);
        is_iset   = (r_cmd == CMD_WR) && mapped && (ra == A_ISET);
    end

    always_comb begin
        ack_self = r_iself[oo] && !r_imask[oo][1];
        ack_norm = !r_imask[oo][0] && (|(r_ipend[oo] & cmask));
        if (ack_self) ack_val = ACK_SELF;
        else if (ack_norm) ack_val = ACK_NORM;
        else ack_val = '0;
        for (int i = 0; i < MAX_CPUS; i++) begin
            raise_iset[i] = cmask[i] && r_wdata[i] && !r_imask[i][0];
        end
        if (r_wdata[31] && !r_imask[oo][1]) raise_iset[oo] = 1'b1;
        lower_vec = MAX_CPUS'(1) << oo;
        for (int i = 0; i < MAX_CPUS; i++) begin
            m_pend[i] = cmask[i] ? (r_ipend[i] | r_idefr[i]) : r_ipend[i];
            m_self[i] = cmask[i] ? (r_iself[i] | r_idself[i]) : r_iself[i];
        end
        intr0 = '0;
        for (int i = 0; i < MAX_CPUS; i++) begin
            intr0[i] = cmask[i] && ((m_self[i] && !r_imask[i][1])
                       || (!r_imask[i][0] && (|(m_pend[i] & cmask))));
        end
    end

    always_comb begin
        if (!mapped) rd_val = ALL_ONES;
        else if (ra == A_REV) rd_val = REVISION;
        else if (ra == A_CAP) rd_val = ((32'(nc) - 32'd1) << 16) | 32'(nlines);
        else if (ra == A_GCFG) rd_val = r_gcfg;
        else if (ra == A_WHO) rd_val = 32'(oo);
        else if (ra == A_MSET || ra == A_MCLR) rd_val = {r_imask[oo][1], 30'd0, r_imask[oo][0]};
        else if (in_dest) rd_val = '0;
        else if (in_mset || in_mclr) rd_val = w_mask;
        else if (in_prd) rd_val = w_pend;
        else rd_val = ALL_ONES;
    end

    always_comb begin
        unique case (r_cmd)
            CMD_WR:  op = (mapped && ra == A_SRST) ? OP_SOFT : OP_ONE;
            CMD_RD:  op = is_ack ? OP_ACK : ((mapped && in_dest) ? OP_RDDEST : OP_ONE);
            CMD_LVL: op = OP_ONE;
            default: op = OP_TICK;
        endcase
    end

    // Routing step for the line leaving the read stage.
    always_comb begin
        hit_ack = r_qv && r_live_q && r_dout[oo];
        ev_tick = r_qv && r_live_q && (r_dout != '0);
        dlo     = r_dout[MAX_CPUS-1:0];
        dext    = r_dout[MAX_CPUS:0];
        avail   = r_cand & ~r_intr[MAX_CPUS-1:0] & cmask;
        first   = nc;
        pick    = '0;
        found   = 1'b0;
        for (int i = MAX_CPUS - 1; i >= 0; i--) begin
            if (dlo[i] && cmask[i]) first = NCW'(i);
            if (avail[i]) begin
                pick  = CW'(i);
                found = 1'b1;
            end
        end
        n_intr = r_intr;
        n_cand = r_cand;
        if (ev_tick) begin
            if ((r_intr & dext) == '0) begin
                n_intr[first] = 1'b1;
                n_cand        = r_cand | dlo;
            end else if (found) begin
                n_intr[pick] = 1'b1;
            end
        end
        scan_last = r_qv && (r_nq == LW'(nlines - LW'(1)));
        scan_done = scan_last || ((r_cmd == CMD_RD) && hit_ack);
    end

    always_comb begin
        o_stat.op         = op;
        o_stat.ipi_hit    = ack_self || ack_norm;
        o_stat.sweep_last = (r_n == LW'(MAX_LINES - 1));
        o_stat.scan_done  = scan_done;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_cpu   <= i_cpu;
            r_addr  <= i_addr;
            r_wdata <= i_wdata;
            r_line  <= i_line;
            r_level <= i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cpus  <= CFG_CPUS_RST;
            r_num_words <= CFG_WORDS_RST;
            r_gcfg      <= '0;
            for (int w = 0; w < NWORDS; w++) begin
                r_pend[w] <= '0;
                r_mask[w] <= '1;
            end
            for (int i = 0; i < MAX_CPUS; i++) begin
                r_ipend[i] <= '0;
                r_idefr[i] <= '0;
                r_imask[i] <= 2'b11;
            end
            r_iself  <= '0;
            r_idself <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_NUM_CPUS) r_num_cpus <= i_cfg_data[2:0];
                else r_num_words <= i_cfg_data;
            end
            if (i_ctl.exec) begin
                unique case (r_cmd)
                    CMD_WR: begin
                        if (mapped) begin
                            unique case (ra)
                                A_SRST: begin
                                    for (int w = 0; w < NWORDS; w++) r_mask[w] <= '1;
                                    for (int i = 0; i < MAX_CPUS; i++) begin
                                        r_ipend[i] <= '0;
                                        r_idefr[i] <= '0;
                                        r_imask[i] <= 2'b11;
                                    end
                                    r_iself  <= '0;
                                    r_idself <= '0;
                                end
                                A_GCFG: r_gcfg <= r_wdata;
                                A_ISET: begin
                                    for (int i = 0; i < MAX_CPUS; i++) begin
                                        if (cmask[i] && r_wdata[i]) r_ipend[i][oo] <= 1'b1;
                                    end
                                    if (r_wdata[31]) r_iself[oo] <= 1'b1;
                                end
                                A_ICLR: begin
                                    for (int i = 0; i < MAX_CPUS; i++) begin
                                        if (cmask[i] && r_wdata[i]) r_ipend[i][oo] <= 1'b0;
                                    end
                                    if (r_wdata[31]) r_iself[oo] <= 1'b0;
                                end
                                A_MSET: r_imask[oo] <= r_imask[oo] | {r_wdata[31], r_wdata[0]};
                                A_MCLR: r_imask[oo] <= r_imask[oo] & ~{r_wdata[31], r_wdata[0]};
                                A_DSET: begin
                                    for (int i = 0; i < MAX_CPUS; i++) begin
                                        if (cmask[i] && r_wdata[i]) r_idefr[i][oo] <= 1'b1;
                                    end
                                    if (r_wdata[31]) r_idself[oo] <= 1'b1;
                                end
                                A_DCLR: begin
                                    for (int i = 0; i < MAX_CPUS; i++) begin
                                        if (cmask[i] && r_wdata[i]) r_idefr[i][oo] <= 1'b0;
                                    end
                                    if (r_wdata[31]) r_idself[oo] <= 1'b0;
                                end
                                default: begin
                                    if (in_pset) r_pend[kw] <= w_pend | r_wdata;
                                    else if (in_pclr) r_pend[kw] <= w_pend & ~r_wdata;
                                    else if (in_mset) r_mask[kw] <= w_mask | r_wdata;
                                    else if (in_mclr) r_mask[kw] <= w_mask & ~r_wdata;
                                end
                            endcase
                        end
                    end
                    CMD_RD: begin
                        if (is_ack) begin
                            if (ack_self) r_imask[oo][1] <= 1'b1;
                            else if (ack_norm) r_imask[oo][0] <= 1'b1;
                        end
                    end
                    CMD_LVL: begin
                        if (line_ok) r_pend[lw][lb] <= r_level;
                    end
                    default: begin
                        for (int i = 0; i < MAX_CPUS; i++) begin
                            if (cmask[i]) begin
                                r_ipend[i]  <= m_pend[i];
                                r_iself[i]  <= m_self[i];
                                r_idefr[i]  <= '0;
                                r_idself[i] <= 1'b0;
                            end
                        end
                    end
                endcase
            end
            if (i_ctl.scan && (r_cmd == CMD_RD) && hit_ack) r_mask[qw][qb] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n  <= '0;
            r_qv <= 1'b0;
        end else if (i_ctl.exec) begin
            r_n  <= '0;
            r_qv <= 1'b0;
        end else if (i_ctl.sweep) begin
            r_n <= r_n + LW'(1);
        end else if (i_ctl.scan) begin
            if (r_n != nlines) begin
                r_n  <= r_n + LW'(1);
                r_qv <= 1'b1;
            end else begin
                r_qv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            r_nq     <= r_n;
            r_live_q <= w_pend[sb] & ~w_mask[sb];
        end
    end

    always_comb begin
        mem_we    = i_ctl.sweep || (i_ctl.exec && (r_cmd == CMD_WR) && mapped && in_dest);
        waddr     = i_ctl.sweep ? r_n[AW-1:0] : kd;
        mem_wdata = i_ctl.sweep ? '0 : r_wdata;
        raddr     = i_ctl.scan ? r_n[AW-1:0] : kd;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_dest[waddr] <= mem_wdata;
        r_dout <= r_dest[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            if (r_cmd != CMD_RD) r_rd <= '0;
            else if (is_ack) r_rd <= ack_val;
            else r_rd <= rd_val;
            r_raise <= is_iset ? raise_iset : '0;
            r_lower <= is_ack ? lower_vec : '0;
            r_intr  <= intr0;
            r_cand  <= '0;
        end else if (i_ctl.grab) begin
            r_rd <= r_dout;
        end else if (i_ctl.scan) begin
            r_intr <= n_intr;
            r_cand <= n_cand;
            if (r_cmd == CMD_RD) begin
                if (hit_ack) r_rd <= ACK_LINE | (32'(r_nq) & LINE_MASK);
            end else if (scan_done) begin
                r_raise <= n_intr[MAX_CPUS-1:0] & cmask;
            end
        end
    end

    assign raise_pad = {6'd0, r_raise};
    assign lower_pad = {6'd0, r_lower};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out_rd    <= r_rd;
            r_out_raise <= raise_pad[5:0];
            r_out_lower <= lower_pad[5:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_out_rd;
    assign o_raise_mask = r_out_raise;
    assign o_lower_mask = r_out_lower;

endmodule
`default_nettype wire

// ----- design/multicore_interrupt_controller.sv -----
// Channel   Handshake                  Payload
// request   i_in_valid / o_in_ready    i_cmd i_cpu i_addr i_wdata i_line i_level
// result    o_out_valid / i_out_ready  o_read_data o_raise_mask o_lower_mask
// config    i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// A register access or level change passes through the EXEC and DONE states from acceptance to result;
// a destination read also passes through the DEST state, which takes the registered memory read data.
// A soft reset write also clears the destination memory with a sweep over all MAX_LINES entries.
// An acknowledge that finds no IPI, and a tick, scan at most the lines in use,
// one line per cycle through the destination memory read port.
// After reset a clearing pass over all MAX_LINES entries runs before the first request is taken.
// A request is taken while an earlier result still waits in the output register.
`default_nettype none
module multicore_interrupt_controller #(
    parameter int MAX_CPUS  = mic_pkg::MIC_MAX_CPUS,
    parameter int MAX_LINES = mic_pkg::MIC_MAX_LINES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [2:0]  i_cpu,
    input  logic [15:0] i_addr,
    input  logic [31:0] i_wdata,
    input  logic [9:0]  i_line,
    input  logic        i_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic [5:0]  o_raise_mask,
    output logic [5:0]  o_lower_mask,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data
);
    import mic_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    mic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (ctl)
    );

    mic_dp #(
        .MAX_CPUS  (MAX_CPUS),
        .MAX_LINES (MAX_LINES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_cmd),
        .i_cpu        (i_cpu),
        .i_addr       (i_addr),
        .i_wdata      (i_wdata),
        .i_line       (i_line),
        .i_level      (i_level),
        .i_out_ready  (i_out_ready),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_read_data  (o_read_data),
        .o_raise_mask (o_raise_mask),
        .o_lower_mask (o_lower_mask)
    );

endmodule
`default_nettype wire

// ----- design/mic_chk.sv -----
`default_nettype none
module mic_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_read_data,
    input logic [5:0]  o_raise_mask,
    input logic [5:0]  o_lower_mask
);

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another was in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_read_data)
            && $stable(o_raise_mask) && $stable(o_lower_mask)))
        else $error("stalled result changed");

    // An acknowledge lowers exactly the reading CPU and raises nothing.
    a_lower_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_lower_mask))
        else $error("more than one CPU lowered");

    a_raise_lower_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_lower_mask != 6'd0)) |-> (o_raise_mask == 6'd0))
        else $error("one result both raises and lowers");

endmodule

bind multicore_interrupt_controller mic_chk u_mic_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_data  (o_read_data),
    .o_raise_mask (o_raise_mask),
    .o_lower_mask (o_lower_mask)
);
`default_nettype wire
